// ----- hdl/vig_pkg.sv -----
// shared types and constants for the radial vignette gain block
package vig_pkg;

   // register indexes of the control port
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_STRENGTH       = 2'd2,
      CSR_INV_MAX_RADIUS = 2'd3
   } csr_index_type;

   // field widths
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int STRENGTH_W = 16;
   localparam int INV_W      = 24;
   localparam int CH_W       = 8;
   localparam int CSR_DATA_W = 24;

   // squared distance: 2 * 4095^2 fits 25 bits
   localparam int D2_W     = 25;
   // square root operand is d2 shifted up by 16
   localparam int SQ_IN_W  = D2_W + 16;
   localparam int ROOT_W   = 21;
   localparam int SQ_CMP_W = SQ_IN_W + 2;

   // register reset values
   localparam logic [DIM_W-1:0]      WIDTH_RESET    = 13'd1920;
   localparam logic [DIM_W-1:0]      HEIGHT_RESET   = 13'd1080;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd32768;
   localparam logic [INV_W-1:0]      INV_RESET      = 24'd15232;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DIM_W-1:0]      image_width;
      logic [DIM_W-1:0]      image_height;
      logic [STRENGTH_W-1:0] strength;
      logic [INV_W-1:0]      inv_max_radius;
   } vig_cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } vig_pixel_type;

   typedef struct packed {
      logic [D2_W-1:0] d2;
      vig_pixel_type   pix;
   } vig_item_type;

endpackage

// ----- hdl/vig_front.sv -----
// front end: accepts pixels, finds the offset from the centre and the squared distance
module vig_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vig_pkg::vig_cfg_type               cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [vig_pkg::COORD_W-1:0]        col,
   input  logic [vig_pkg::COORD_W-1:0]        row_index,
   input  vig_pkg::vig_pixel_type             pix,
   input  logic                               q_full,
   output logic                               push,
   output vig_pkg::vig_item_type              push_item
);

   localparam logic [14:0] DIM_LIMIT = 15'(MAX_DIM);

   logic [14:0]                   width_c;
   logic [14:0]                   height_c;
   logic [vig_pkg::COORD_W-1:0]   cx;
   logic [vig_pkg::COORD_W-1:0]   cy;
   logic                          adv;

   logic                          s1_valid_ff, s1_valid_in;
   logic [vig_pkg::COORD_W-1:0]   dx_ff, dx_in;
   logic [vig_pkg::COORD_W-1:0]   dy_ff, dy_in;
   vig_pkg::vig_pixel_type        s1_pix_ff, s1_pix_in;

   logic                          s2_valid_ff, s2_valid_in;
   vig_pkg::vig_item_type         s2_item_ff, s2_item_in;

   logic [2*vig_pkg::COORD_W-1:0] dx_sq;
   logic [2*vig_pkg::COORD_W-1:0] dy_sq;

   // centre from the clamped frame size
   always_comb begin
      width_c  = ({2'b00, cfg.image_width} > DIM_LIMIT) ? DIM_LIMIT : {2'b00, cfg.image_width};
      height_c = ({2'b00, cfg.image_height} > DIM_LIMIT) ? DIM_LIMIT : {2'b00, cfg.image_height};
      cx       = width_c[vig_pkg::COORD_W:1];
      cy       = height_c[vig_pkg::COORD_W:1];
   end

   // both front stages move together unless the queue holds the last one back
   assign adv       = !s2_valid_ff || !q_full;
   assign req_ready = adv;
   assign push      = s2_valid_ff && !q_full;
   assign push_item = s2_item_ff;

   // stage one: absolute offsets
   always_comb begin
      s1_valid_in = req_valid;
      dx_in       = (col >= cx) ? (col - cx) : (cx - col);
      dy_in       = (row_index >= cy) ? (row_index - cy) : (cy - row_index);
      s1_pix_in   = pix;
   end

   // stage two: squared distance
   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;

   always_comb begin
      s2_valid_in    = s1_valid_ff;
      s2_item_in.d2  = {1'b0, dx_sq} + {1'b0, dy_sq};
      s2_item_in.pix = s1_pix_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         s1_pix_ff  <= s1_pix_in;
         s2_item_ff <= s2_item_in;
      end
   end

endmodule

// ----- hdl/vig_queue.sv -----
// small request queue between the front end and the gain pipeline
module vig_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vig_pkg::vig_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output vig_pkg::vig_item_type pop_item
);

   vig_pkg::vig_item_type          entry_ff [vig_pkg::QUEUE_DEPTH];
   logic [vig_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [vig_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [vig_pkg::CNT_W-1:0]      count_ff, count_in;

   assign full     = (count_ff == vig_pkg::CNT_W'(vig_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vig_pkg::CNT_W'(vig_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("request popped from empty queue");
`endif

endmodule

// ----- hdl/vig_back.sv -----
// back end: pipelined square root, radius, gain and channel scaling
module vig_back #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vig_pkg::vig_cfg_type         cfg,
   input  logic                         q_empty,
   input  vig_pkg::vig_item_type        q_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output vig_pkg::vig_pixel_type       rsp_pix
);

   localparam int GW       = GAIN_FRAC_BITS;
   localparam int GAIN_W   = GW + 1;
   localparam int R_PROD_W = vig_pkg::ROOT_W + vig_pkg::INV_W;
   localparam int R_W      = R_PROD_W + 1 - 16;
   localparam int T_W      = R_W + 1;
   localparam int P_W      = vig_pkg::STRENGTH_W + T_W;
   localparam int DS_W     = P_W + 1;
   localparam int DROP_W   = DS_W - (32 - GW);
   localparam int SC_W     = vig_pkg::CH_W + GAIN_W + 1;

   localparam logic [R_PROD_W:0]   R_ROUND  = (R_PROD_W + 1)'(32768);
   localparam logic [R_W-1:0]      R_MID    = R_W'(32768);
   localparam logic [DS_W-1:0]     P_ROUND  = DS_W'(1) << (31 - GW);
   localparam logic [DROP_W-1:0]   DROP_ONE = DROP_W'(1) << GW;
   localparam logic [GAIN_W-1:0]   GAIN_ONE = GAIN_W'(1) << GW;
   localparam logic [SC_W-1:0]     SC_ROUND = SC_W'(1) << (GW - 1);

   logic en;

   // square root pipeline, stage 0 holds the popped request
   logic                           sq_valid_ff [vig_pkg::ROOT_W+1];
   logic [vig_pkg::SQ_IN_W-1:0]    sq_rem_ff   [vig_pkg::ROOT_W+1];
   logic [vig_pkg::SQ_IN_W-1:0]    sq_rem_in   [vig_pkg::ROOT_W+1];
   logic [vig_pkg::ROOT_W-1:0]     sq_root_ff  [vig_pkg::ROOT_W+1];
   logic [vig_pkg::ROOT_W-1:0]     sq_root_in  [vig_pkg::ROOT_W+1];
   vig_pkg::vig_pixel_type         sq_pix_ff   [vig_pkg::ROOT_W+1];

   logic                           r_valid_ff;
   logic [R_W-1:0]                 r_ff, r_in;
   vig_pkg::vig_pixel_type         r_pix_ff;
   logic [R_PROD_W-1:0]            r_prod;
   logic [R_PROD_W:0]              r_sum;

   logic                           p_valid_ff;
   logic [P_W-1:0]                 p_ff, p_in;
   vig_pkg::vig_pixel_type         p_pix_ff;
   logic [T_W-1:0]                 t_val;

   logic                           g_valid_ff;
   logic [GAIN_W-1:0]              gain_ff, gain_in;
   vig_pkg::vig_pixel_type         g_pix_ff;
   logic [DS_W-1:0]                drop_sum;
   logic [DROP_W-1:0]              drop;

   logic                           out_valid_ff;
   vig_pkg::vig_pixel_type         out_pix_ff, out_pix_in;
   logic [SC_W-1:0]                sc_blue;
   logic [SC_W-1:0]                sc_green;
   logic [SC_W-1:0]                sc_red;

   // whole pipeline advances while the output slot is free or being taken
   assign en        = !out_valid_ff || rsp_ready;
   assign pop       = en && !q_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_pix   = out_pix_ff;

   // square root operand loaded from the queue
   assign sq_rem_in[0]  = {q_item.d2, 16'b0};
   assign sq_root_in[0] = '0;

   // one root bit per stage, most significant first
   for (genvar k = 0; k < vig_pkg::ROOT_W; k++) begin : g_sqrt
      localparam int BIT = vig_pkg::ROOT_W - 1 - k;
      logic [vig_pkg::SQ_CMP_W-1:0] trial;
      logic                         take;

      always_comb begin
         trial = (vig_pkg::SQ_CMP_W'(sq_root_ff[k]) << (BIT + 1))
               + (vig_pkg::SQ_CMP_W'(1) << (2 * BIT));
         take  = vig_pkg::SQ_CMP_W'(sq_rem_ff[k]) >= trial;
         sq_rem_in[k+1]  = take ? vig_pkg::SQ_IN_W'(vig_pkg::SQ_CMP_W'(sq_rem_ff[k]) - trial)
                                : sq_rem_ff[k];
         sq_root_in[k+1] = take ? (sq_root_ff[k] | (vig_pkg::ROOT_W'(1) << BIT))
                                : sq_root_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= vig_pkg::ROOT_W; i++) begin
            sq_valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         sq_valid_ff[0] <= pop;
         for (int i = 1; i <= vig_pkg::ROOT_W; i++) begin
            sq_valid_ff[i] <= sq_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_pix_ff[0] <= q_item.pix;
         for (int i = 0; i <= vig_pkg::ROOT_W; i++) begin
            sq_rem_ff[i]  <= sq_rem_in[i];
            sq_root_ff[i] <= sq_root_in[i];
         end
         for (int i = 1; i <= vig_pkg::ROOT_W; i++) begin
            sq_pix_ff[i] <= sq_pix_ff[i-1];
         end
      end
   end

   // normalised radius, rounded to Q16
   assign r_prod = sq_root_ff[vig_pkg::ROOT_W] * cfg.inv_max_radius;
   assign r_sum  = {1'b0, r_prod} + R_ROUND;
   assign r_in   = r_sum[R_PROD_W:16];

   // falloff beyond half radius times strength
   always_comb begin
      t_val = (r_ff > R_MID) ? {r_ff - R_MID, 1'b0} : '0;
      p_in  = cfg.strength * t_val;
   end

   // gain with saturation at zero
   always_comb begin
      drop_sum = {1'b0, p_ff} + P_ROUND;
      drop     = drop_sum[DS_W-1:32-GW];
      gain_in  = (drop >= DROP_ONE) ? '0 : GAIN_W'(DROP_ONE - drop);
   end

   // channel scaling, rounded to nearest
   always_comb begin
      sc_blue            = SC_W'(g_pix_ff.blue * gain_ff) + SC_ROUND;
      sc_green           = SC_W'(g_pix_ff.green * gain_ff) + SC_ROUND;
      sc_red             = SC_W'(g_pix_ff.red * gain_ff) + SC_ROUND;
      out_pix_in.blue    = sc_blue[GW+vig_pkg::CH_W-1:GW];
      out_pix_in.green   = sc_green[GW+vig_pkg::CH_W-1:GW];
      out_pix_in.red     = sc_red[GW+vig_pkg::CH_W-1:GW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff   <= sq_valid_ff[vig_pkg::ROOT_W];
         p_valid_ff   <= r_valid_ff;
         g_valid_ff   <= p_valid_ff;
         out_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff       <= r_in;
         r_pix_ff   <= sq_pix_ff[vig_pkg::ROOT_W];
         p_ff       <= p_in;
         p_pix_ff   <= r_pix_ff;
         gain_ff    <= gain_in;
         g_pix_ff   <= p_pix_ff;
         out_pix_ff <= out_pix_in;
      end
   end

`ifndef SYNTHESIS
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff |-> (gain_ff <= GAIN_ONE))
      else $error("gain above unity");
   a_gain_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && g_valid_ff) |=> $stable(gain_ff))
      else $error("gain changed while pipeline stalled");
   a_root_to_radius: assert property (@(posedge clock) disable iff (reset)
      (en && sq_valid_ff[vig_pkg::ROOT_W]) |=> r_valid_ff)
      else $error("request lost between root and radius stages");
`endif

endmodule

// ----- hdl/radial_vignette_gain_top.sv -----
// Radial vignette gain: one BGR pixel in, the same pixel scaled by a radial gain out.
// Path from request accept to rsp_valid: two front stages, the queue,
// a 21-stage square root pipeline with one root bit per stage, then radius, falloff,
// gain and scaling stages. Throughput: one pixel per clock, stalling only on rsp_ready.
// Reset: synchronous, active high; empties the pipeline and queue and loads the
// registers with 1920 x 1080, strength one half and reciprocal radius 15232.
module radial_vignette_gain_top #(
   parameter int MAX_DIM        = 4096,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [vig_pkg::COORD_W-1:0]      req_col,
   input  logic [vig_pkg::COORD_W-1:0]      req_row_index,
   input  logic [vig_pkg::CH_W-1:0]         req_blue_in,
   input  logic [vig_pkg::CH_W-1:0]         req_green_in,
   input  logic [vig_pkg::CH_W-1:0]         req_red_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [vig_pkg::CH_W-1:0]         rsp_blue_out,
   output logic [vig_pkg::CH_W-1:0]         rsp_green_out,
   output logic [vig_pkg::CH_W-1:0]         rsp_red_out,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [vig_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   vig_pkg::vig_cfg_type    cfg_ff, cfg_in;
   vig_pkg::vig_pixel_type  req_pix;
   vig_pkg::vig_pixel_type  rsp_pix;
   vig_pkg::vig_item_type   push_item;
   vig_pkg::vig_item_type   pop_item;
   logic                    push;
   logic                    pop;
   logic                    q_full;
   logic                    q_empty;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            vig_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata[vig_pkg::DIM_W-1:0];
            end
            vig_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata[vig_pkg::DIM_W-1:0];
            end
            vig_pkg::CSR_STRENGTH: begin
               cfg_in.strength = csr_wdata[vig_pkg::STRENGTH_W-1:0];
            end
            vig_pkg::CSR_INV_MAX_RADIUS: begin
               cfg_in.inv_max_radius = csr_wdata[vig_pkg::INV_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= vig_pkg::WIDTH_RESET;
         cfg_ff.image_height   <= vig_pkg::HEIGHT_RESET;
         cfg_ff.strength       <= vig_pkg::STRENGTH_RESET;
         cfg_ff.inv_max_radius <= vig_pkg::INV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pixel bundling
   assign req_pix.blue  = req_blue_in;
   assign req_pix.green = req_green_in;
   assign req_pix.red   = req_red_in;

   assign rsp_blue_out  = rsp_pix.blue;
   assign rsp_green_out = rsp_pix.green;
   assign rsp_red_out   = rsp_pix.red;

   vig_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .col       (req_col),
      .row_index (req_row_index),
      .pix       (req_pix),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   vig_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   vig_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pix   (rsp_pix)
   );

endmodule

// ----- tb/vig_checker.sv -----
`timescale 1ns / 1ps
// checker for the radial vignette gain block: snoops the ports, predicts each pixel, compares
module vig_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [vig_pkg::COORD_W-1:0]    req_col,
   input  logic [vig_pkg::COORD_W-1:0]    req_row_index,
   input  logic [vig_pkg::CH_W-1:0]       req_blue_in,
   input  logic [vig_pkg::CH_W-1:0]       req_green_in,
   input  logic [vig_pkg::CH_W-1:0]       req_red_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [vig_pkg::CH_W-1:0]       rsp_blue_out,
   input  logic [vig_pkg::CH_W-1:0]       rsp_green_out,
   input  logic [vig_pkg::CH_W-1:0]       rsp_red_out,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [vig_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   localparam longint unsigned MAX_DIM   = 4096;
   localparam int              GAIN_BITS = 16;
   localparam longint unsigned UNITY     = 64'd1 << GAIN_BITS;

   // shadow copy of the control registers
   logic [vig_pkg::DIM_W-1:0]      cfg_width;
   logic [vig_pkg::DIM_W-1:0]      cfg_height;
   logic [vig_pkg::STRENGTH_W-1:0] cfg_strength;
   logic [vig_pkg::INV_W-1:0]      cfg_inv_radius;

   vig_pkg::vig_pixel_type shaded_pixels[$];
   vig_pkg::vig_pixel_type want;
   vig_pkg::vig_pixel_type req_pix;
   int                     errors = 0;

   // floor square root, one result bit per step
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 22; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // channel times gain, rounded half up
   function automatic logic [vig_pkg::CH_W-1:0] apply_gain(input logic [vig_pkg::CH_W-1:0] c,
                                                           input longint unsigned gain);
      longint unsigned prod;
      prod = 64'(c) * gain + (64'd1 << (GAIN_BITS - 1));
      return vig_pkg::CH_W'(prod >> GAIN_BITS);
   endfunction

   // expected pixel for a position under the current register settings
   function automatic vig_pkg::vig_pixel_type shade_pixel(
         input logic [vig_pkg::COORD_W-1:0] x,
         input logic [vig_pkg::COORD_W-1:0] y,
         input vig_pkg::vig_pixel_type pin);
      longint unsigned        wd, ht, cx, cy, dx, dy, d2, dist_q8, rad, t, p, drop, gain;
      vig_pkg::vig_pixel_type pout;
      wd      = (64'(cfg_width) > MAX_DIM) ? MAX_DIM : 64'(cfg_width);
      ht      = (64'(cfg_height) > MAX_DIM) ? MAX_DIM : 64'(cfg_height);
      cx      = wd / 2;
      cy      = ht / 2;
      dx      = (64'(x) >= cx) ? 64'(x) - cx : cx - 64'(x);
      dy      = (64'(y) >= cy) ? 64'(y) - cy : cy - 64'(y);
      d2      = dx * dx + dy * dy;
      dist_q8 = int_sqrt(d2 << 16);
      rad     = (dist_q8 * 64'(cfg_inv_radius) + (64'd1 << 15)) >> 16;
      // falloff only beyond half the radius, no clamp above one
      t       = (rad > 64'd32768) ? (rad - 64'd32768) * 2 : 64'd0;
      p       = 64'(cfg_strength) * t;
      drop    = (p + (64'd1 << (31 - GAIN_BITS))) >> (32 - GAIN_BITS);
      gain    = (drop >= UNITY) ? 64'd0 : UNITY - drop;
      pout.blue  = apply_gain(pin.blue, gain);
      pout.green = apply_gain(pin.green, gain);
      pout.red   = apply_gain(pin.red, gain);
      return pout;
   endfunction

   task automatic check_channel(input string name, input logic [vig_pkg::CH_W-1:0] exp_v,
                                input logic [vig_pkg::CH_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // register shadow, prediction on request, comparison on response
   always @(posedge clock) begin
      if (reset) begin
         cfg_width      = vig_pkg::WIDTH_RESET;
         cfg_height     = vig_pkg::HEIGHT_RESET;
         cfg_strength   = vig_pkg::STRENGTH_RESET;
         cfg_inv_radius = vig_pkg::INV_RESET;
         shaded_pixels.delete();
      end else begin
         if (csr_we) begin
            case (vig_pkg::csr_index_type'(csr_index))
               vig_pkg::CSR_IMAGE_WIDTH: begin
                  cfg_width = csr_wdata[vig_pkg::DIM_W-1:0];
               end
               vig_pkg::CSR_IMAGE_HEIGHT: begin
                  cfg_height = csr_wdata[vig_pkg::DIM_W-1:0];
               end
               vig_pkg::CSR_STRENGTH: begin
                  cfg_strength = csr_wdata[vig_pkg::STRENGTH_W-1:0];
               end
               vig_pkg::CSR_INV_MAX_RADIUS: begin
                  cfg_inv_radius = csr_wdata[vig_pkg::INV_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            req_pix.blue  = req_blue_in;
            req_pix.green = req_green_in;
            req_pix.red   = req_red_in;
            shaded_pixels.push_back(shade_pixel(req_col, req_row_index, req_pix));
         end
         if (rsp_valid && rsp_ready) begin
            if (shaded_pixels.size() == 0) begin
               errors++;
               $display("%0t: response with no request, expected none, actual %0d %0d %0d",
                        $time, rsp_blue_out, rsp_green_out, rsp_red_out);
            end else begin
               want = shaded_pixels.pop_front();
               check_channel("blue", want.blue, rsp_blue_out);
               check_channel("green", want.green, rsp_green_out);
               check_channel("red", want.red, rsp_red_out);
            end
         end
      end
      fail_count <= errors;
      pending    <= shaded_pixels.size();
   end

endmodule

// ----- tb/radial_vignette_gain_top_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the radial vignette gain block: stimulus, response stalls and verdict
module radial_vignette_gain_top_tb;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 105;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_WAIT      = 19;

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   logic [vig_pkg::COORD_W-1:0]    req_col       = '0;
   logic [vig_pkg::COORD_W-1:0]    req_row_index = '0;
   logic [vig_pkg::CH_W-1:0]       req_blue_in   = '0;
   logic [vig_pkg::CH_W-1:0]       req_green_in  = '0;
   logic [vig_pkg::CH_W-1:0]       req_red_in    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic [vig_pkg::CH_W-1:0]       rsp_blue_out;
   logic [vig_pkg::CH_W-1:0]       rsp_green_out;
   logic [vig_pkg::CH_W-1:0]       rsp_red_out;
   logic                           csr_we        = 1'b0;
   logic [1:0]                     csr_index     = '0;
   logic [vig_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;

   int fail_count;
   int pending;
   bit idle_on = 1'b1;

   radial_vignette_gain_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_col       (req_col),
      .req_row_index (req_row_index),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   vig_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_col       (req_col),
      .req_row_index (req_row_index),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // watchdog
   initial begin
      #3_000_000;
      $display("FAIL radial_vignette_gain_top");
      $finish;
   end

   // response side: random stall before each response while idle_on is set
   initial begin : rsp_side
      int stall;
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // one request after a random gap while idle_on is set, held until accepted
   task automatic send_pixel(input logic [vig_pkg::COORD_W-1:0] x,
                             input logic [vig_pkg::COORD_W-1:0] y,
                             input logic [vig_pkg::CH_W-1:0] b,
                             input logic [vig_pkg::CH_W-1:0] g,
                             input logic [vig_pkg::CH_W-1:0] r);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_col       <= x;
      req_row_index <= y;
      req_blue_in   <= b;
      req_green_in  <= g;
      req_red_in    <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait until every request has its response
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // write all four registers, block idle
   task automatic program_regs(input logic [vig_pkg::DIM_W-1:0] w,
                               input logic [vig_pkg::DIM_W-1:0] h,
                               input logic [vig_pkg::STRENGTH_W-1:0] s,
                               input logic [vig_pkg::INV_W-1:0] inv);
      csr_we    <= 1'b1;
      csr_index <= vig_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= vig_pkg::CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= vig_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= vig_pkg::CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= vig_pkg::CSR_STRENGTH;
      csr_wdata <= vig_pkg::CSR_DATA_W'(s);
      @(posedge clock);
      csr_index <= vig_pkg::CSR_INV_MAX_RADIUS;
      csr_wdata <= vig_pkg::CSR_DATA_W'(inv);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin : stimulus
      logic [vig_pkg::DIM_W-1:0]      w, h;
      logic [vig_pkg::STRENGTH_W-1:0] s;
      logic [vig_pkg::INV_W-1:0]      inv;
      logic [vig_pkg::COORD_W-1:0]    x, y;
      logic [vig_pkg::CH_W-1:0]       b, g, r;
      int                             eff_w, eff_h, sel;
      real                            corner_span, ratio;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: centre, half radius, frame corners, far outside
      send_pixel(12'd960, 12'd540, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd1200, 12'd700, 8'd200, 8'd100, 8'd50);
      send_pixel(12'd0, 12'd0, 8'd255, 8'd128, 8'd1);
      send_pixel(12'd1919, 12'd1079, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd0, 12'd540, 8'hAA, 8'h55, 8'hFF);
      send_pixel(12'd960, 12'd0, 8'h55, 8'hAA, 8'h00);
      send_pixel(12'd1500, 12'd540, 8'd255, 8'd0, 8'd127);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd255);
      send_pixel(12'd4095, 12'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(12'd0, 12'd4095, 8'd1, 8'd254, 8'd128);
      wait_drained();

      // zero reciprocal passes everything unchanged
      program_regs(13'd1920, 13'd1080, 16'hFFFF, 24'd0);
      send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd4095, 12'd4095, 8'd17, 8'd200, 8'd255);
      wait_drained();

      // tiny dimensions put the centre at zero, maximum reciprocal saturates the gain
      program_regs(13'd0, 13'd1, 16'hFFFF, 24'hFFFFFF);
      send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd1, 12'd0, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd128, 8'd64);
      wait_drained();

      // oversized dimensions clamp, zero strength
      program_regs(13'd8191, 13'd4097, 16'd0, 24'd1);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd0, 12'd0, 8'd99, 8'd0, 8'd255);
      send_pixel(12'd2048, 12'd2048, 8'd255, 8'd1, 8'd2);
      wait_drained();

      // largest frame, full strength, nominal reciprocal: radius runs past one
      program_regs(13'd4096, 13'd4096, 16'hFFFF, 24'd5793);
      send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd2048, 12'd2048, 8'd255, 8'd255, 8'd255);
      send_pixel(12'd3072, 12'd2048, 8'd180, 8'd90, 8'd45);
      send_pixel(12'd4095, 12'd2048, 8'd255, 8'd254, 8'd253);
      wait_drained();

      // random settings, mostly in-frame pixels
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         sel = $urandom_range(0, 9);
         w = (sel == 0) ? vig_pkg::DIM_W'($urandom_range(0, 1)) :
             (sel == 1) ? vig_pkg::DIM_W'($urandom_range(4097, 8191)) :
                          vig_pkg::DIM_W'($urandom_range(2, 4096));
         sel = $urandom_range(0, 9);
         h = (sel == 0) ? vig_pkg::DIM_W'($urandom_range(0, 1)) :
             (sel == 1) ? vig_pkg::DIM_W'($urandom_range(4097, 8191)) :
                          vig_pkg::DIM_W'($urandom_range(2, 4096));
         sel = $urandom_range(0, 7);
         s = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
             vig_pkg::STRENGTH_W'($urandom_range(0, 65535));
         eff_w = (w > 13'd4096) ? 4096 : int'(w);
         eff_h = (h > 13'd4096) ? 4096 : int'(h);
         corner_span = $sqrt(real'((eff_w / 2) * (eff_w / 2) + (eff_h / 2) * (eff_h / 2)));
         sel   = $urandom_range(0, 9);
         if (sel == 0 || corner_span < 1.0) begin
            inv = vig_pkg::INV_W'($urandom);
         end else begin
            ratio = 16777216.0 / corner_span *
                    (0.75 + 0.5 * real'($urandom_range(0, 1000)) / 1000.0);
            if (ratio > 16777215.0) ratio = 16777215.0;
            inv = vig_pkg::INV_W'($rtoi(ratio));
         end
         if (eff_w < 1) eff_w = 1;
         if (eff_h < 1) eff_h = 1;
         program_regs(w, h, s, inv);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 4) != 0) begin
               x = vig_pkg::COORD_W'($urandom_range(0, eff_w - 1));
               y = vig_pkg::COORD_W'($urandom_range(0, eff_h - 1));
            end else begin
               x = vig_pkg::COORD_W'($urandom);
               y = vig_pkg::COORD_W'($urandom);
            end
            b = ($urandom_range(0, 7) == 0) ? 8'hFF : vig_pkg::CH_W'($urandom);
            g = ($urandom_range(0, 7) == 0) ? 8'h00 : vig_pkg::CH_W'($urandom);
            r = vig_pkg::CH_W'($urandom);
            send_pixel(x, y, b, g, r);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d responses still outstanding, expected 0", $time, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS radial_vignette_gain_top");
      end else begin
         $display("FAIL radial_vignette_gain_top");
      end
      $finish;
   end

endmodule
